@@ rtl/mexp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

	// operand width and modulus after reset
	localparam int unsigned VALUE_BITS_DEF = 31;
	localparam logic [63:0] MODULUS_RESET  = 64'd1000000007;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // take a new request, clear the lanes
		logic step;    // one bit of the serial modular multiplier
		logic reduce;  // lane runs base mod modulus instead of a product
		logic finish;  // last bit of a pass, commit the lane results
	} mexp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic e_zero;  // remaining exponent is zero
		logic e_one;   // remaining exponent is one, current pass is the last
	} mexp_stat_t;

endpackage

`default_nettype wire

@@ rtl/mexp_mstep.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mexp_mstep #(
	parameter int unsigned W = 31
) (
	input  wire logic [W-1:0] r,
	input  wire logic [W-1:0] addend,
	input  wire logic [W-1:0] m,
	output logic      [W-1:0] r_next
);

	logic [W:0] dbl;
	logic [W:0] dbl_red;
	logic [W:0] sum;
	logic [W:0] sum_red;

	// r < m and addend < m, so one conditional subtract per add is enough
	always_comb begin
		dbl     = {r, 1'b0};
		dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		sum     = dbl_red + {1'b0, addend};
		sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
		r_next  = sum_red[W-1:0];
	end

endmodule

`default_nettype wire

@@ rtl/mexp_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mexp_dp #(
	parameter int unsigned VALUE_BITS = mexp_pkg::VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mexp_pkg::mexp_cmd_t   cmd,
	output mexp_pkg::mexp_stat_t       stat,
	input  wire logic                  cfg_we,
	input  wire logic [VALUE_BITS-1:0] cfg_modulus,
	input  wire logic [VALUE_BITS-1:0] base,
	input  wire logic [VALUE_BITS-1:0] exponent,
	output logic      [VALUE_BITS-1:0] power_result
);
	import mexp_pkg::*;

	localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);

	logic [VALUE_BITS-1:0] modulus_q;
	logic [VALUE_BITS-1:0] m_eff;
	logic [VALUE_BITS-1:0] acc_q;
	logic [VALUE_BITS-1:0] sq_q;
	logic [VALUE_BITS-1:0] e_q;
	logic [VALUE_BITS-1:0] b_q;
	logic [VALUE_BITS-1:0] r_acc_q;
	logic [VALUE_BITS-1:0] r_sq_q;
	logic [VALUE_BITS-1:0] acc_add;
	logic [VALUE_BITS-1:0] sq_add;
	logic [VALUE_BITS-1:0] acc_next;
	logic [VALUE_BITS-1:0] sq_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET[VALUE_BITS-1:0];
		end else if (cfg_we) begin
			modulus_q <= cfg_modulus;
		end
	end

	// a zero modulus behaves like one
	assign m_eff = (modulus_q == '0) ? ONE : modulus_q;

	// both lanes scan the same multiplier bits (the square, or the base in the reduce pass)
	assign acc_add = b_q[VALUE_BITS-1] ? acc_q : '0;
	assign sq_add  = cmd.reduce ? {{(VALUE_BITS-1){1'b0}}, b_q[VALUE_BITS-1]}
	                            : (b_q[VALUE_BITS-1] ? sq_q : '0);

	mexp_mstep #(.W(VALUE_BITS)) u_acc_lane (
		.r      (r_acc_q),
		.addend (acc_add),
		.m      (m_eff),
		.r_next (acc_next)
	);

	mexp_mstep #(.W(VALUE_BITS)) u_sq_lane (
		.r      (r_sq_q),
		.addend (sq_add),
		.m      (m_eff),
		.r_next (sq_next)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// zero exponent returns 1 unreduced
			acc_q   <= ((exponent == '0) || (m_eff != ONE)) ? ONE : '0;
			e_q     <= exponent;
			b_q     <= base;
			r_acc_q <= '0;
			r_sq_q  <= '0;
		end else if (cmd.step) begin
			if (cmd.finish) begin
				sq_q    <= sq_next;
				b_q     <= sq_next;
				r_acc_q <= '0;
				r_sq_q  <= '0;
				if (!cmd.reduce) begin
					if (e_q[0]) begin
						acc_q <= acc_next;
					end
					e_q <= e_q >> 1;
				end
			end else begin
				b_q     <= b_q << 1;
				r_acc_q <= acc_next;
				r_sq_q  <= sq_next;
			end
		end
	end

	assign stat.e_zero  = (e_q == '0);
	assign stat.e_one   = (e_q == ONE);
	assign power_result = acc_q;

endmodule

`default_nettype wire

@@ rtl/mexp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl #(
	parameter int unsigned VALUE_BITS = mexp_pkg::VALUE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire mexp_pkg::mexp_stat_t stat,
	output mexp_pkg::mexp_cmd_t       cmd,
	output logic                      busy,
	output logic                      done
);
	import mexp_pkg::*;

	localparam int unsigned CNT_W = $clog2(VALUE_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_REDUCE,
		S_MULT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             last;

	assign last = (cnt_q == CNT_LAST);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_REDUCE: begin
				cmd.step   = 1'b1;
				cmd.reduce = 1'b1;
				cmd.finish = last;
			end
			S_MULT: begin
				cmd.step   = 1'b1;
				cmd.finish = last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// done can only be high in idle, so the busy states never clear it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q  <= '0;
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_REDUCE;
						busy_q  <= 1'b1;
					end
				end
				S_REDUCE: begin
					if (last) begin
						cnt_q <= '0;
						if (stat.e_zero) begin
							state_q <= S_IDLE;
							busy_q  <= 1'b0;
							done_q  <= 1'b1;
						end else begin
							state_q <= S_MULT;
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_MULT: begin
					if (last) begin
						cnt_q <= '0;
						if (stat.e_one) begin
							state_q <= S_IDLE;
							busy_q  <= 1'b0;
							done_q  <= 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

`default_nettype wire

@@ rtl/modular_exponentiation_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel     | signals                                  | handshake
// ------------+------------------------------------------+--------------------------------
// request     | start, busy, base, exponent              | taken when start && !busy
// result      | done, power_result                       | done strobe, one cycle, no stall
// modulus cfg | modulus_valid, modulus_ready, modulus    | written when valid && ready
//
// sequence: a reduce pass takes the base mod the modulus, then one multiply/square pass per exponent bit up to
//   the highest set bit; a zero exponent ends after the reduce pass. each pass runs the bit-serial
//   modular multiplier, one multiplier bit per cycle, with the multiply and square lanes running
//   side by side
// reset: arst_n clears the controller and loads the modulus with 1000000007
// stalls: one request in flight; busy stays high until the cycle the done strobe shows

module modular_exponentiation_core #(
	parameter int unsigned VALUE_BITS = mexp_pkg::VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [VALUE_BITS-1:0] base,
	input  wire logic [VALUE_BITS-1:0] exponent,
	// result
	output logic                       done,
	output logic      [VALUE_BITS-1:0] power_result,
	// modulus register
	input  wire logic                  modulus_valid,
	output logic                       modulus_ready,
	input  wire logic [VALUE_BITS-1:0] modulus
);
	import mexp_pkg::*;

	mexp_cmd_t  cmd;
	mexp_stat_t stat;

	// modulus writes are only taken between requests, never in the cycle a request is taken
	assign modulus_ready = ~busy & ~start;

	// sequencer: reduce pass, then one multiply/square pass per exponent bit
	mexp_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// operand registers and the two serial modular multiplier lanes
	mexp_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (modulus_valid & modulus_ready),
		.cfg_modulus  (modulus),
		.base         (base),
		.exponent     (exponent),
		.power_result (power_result)
	);

endmodule

`default_nettype wire

@@ rtl/mexp_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mexp_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic modulus_ready
);

	// an accepted request keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// a result only ends a busy period
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe without a finished request");

	// done is a strobe and is never held high
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// no modulus write while a request is in flight
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !modulus_ready)
		else $error("modulus port ready while busy");

endmodule

bind modular_exponentiation_core mexp_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.modulus_ready (modulus_ready)
);

`default_nettype wire

@@ dv/modular_exponentiation_core_tb.sv @@
`timescale 1ns / 1ps

module modular_exponentiation_core_tb;

	import mexp_pkg::*;

	localparam int unsigned W            = VALUE_BITS_DEF;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned PHASE_ITEMS  = 71;
	// longer than the worst-case request, to catch stray results
	localparam int unsigned DRAIN_CYCLES = 1100;
	// ~600 requests at worst-case length plus gaps, taken four times over
	localparam longint unsigned RUN_LIMIT_NS = 25_000_000;

	localparam logic [W-1:0] ALL_ONES = '1;

	// expected powers, in request order, with a private copy of the modulus
	class power_scoreboard;
		bit [W-1:0]  modulus_now;
		bit [W-1:0]  expected_powers[$];
		int unsigned errors;

		function new();
			modulus_now = MODULUS_RESET[W-1:0];
			errors      = 0;
		endfunction

		// right-to-left square and multiply; products fit in 62 bits
		function bit [W-1:0] mod_pow(bit [W-1:0] b, bit [W-1:0] e);
			longint unsigned m;
			longint unsigned acc;
			longint unsigned sq;
			bit [W-1:0]      rest;
			if (e == 0)
				return 1;
			m = modulus_now;
			if (m == 0)
				m = 1;
			acc  = 1 % m;
			sq   = b % m;
			rest = e;
			while (rest != 0) begin
				if (rest[0])
					acc = (acc * sq) % m;
				sq   = (sq * sq) % m;
				rest = rest >> 1;
			end
			return acc[W-1:0];
		endfunction

		function void note_request(bit [W-1:0] b, bit [W-1:0] e);
			expected_powers.push_back(mod_pow(b, e));
		endfunction

		function void check_result(bit [W-1:0] actual);
			bit [W-1:0] expected;
			if (expected_powers.size() == 0) begin
				$error("power_result: expected none, actual %0d", actual);
				errors++;
				return;
			end
			expected = expected_powers.pop_front();
			if (actual !== expected) begin
				$error("power_result: expected %0d, actual %0d", expected, actual);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_powers.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n        = 1'b0;
	logic         start         = 1'b0;
	logic         busy;
	logic [W-1:0] base          = '0;
	logic [W-1:0] exponent      = '0;
	logic         done;
	logic [W-1:0] power_result;
	logic         modulus_valid = 1'b0;
	logic         modulus_ready;
	logic [W-1:0] modulus       = '0;

	power_scoreboard sb = new();

	modular_exponentiation_core #(
		.VALUE_BITS(W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.base         (base),
		.exponent     (exponent),
		.done         (done),
		.power_result (power_result),
		.modulus_valid(modulus_valid),
		.modulus_ready(modulus_ready),
		.modulus      (modulus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// results cannot be held off: every done strobe is a result
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(power_result);
	end

	// start stays high on return so back-to-back requests need no drop
	task automatic send_request(input logic [W-1:0] b, input logic [W-1:0] e);
		start    <= 1'b1;
		base     <= b;
		exponent <= e;
		do @(posedge clk); while (busy);
		sb.note_request(b, e);
	endtask

	// sender hold-off, either right away or once the block has gone idle
	task automatic request_gap();
		start <= 1'b0;
		if ($urandom_range(0, 1) == 0) begin
			do @(posedge clk); while (busy);
		end
		repeat ($urandom_range(1, 13)) @(posedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// only called with nothing in flight
	task automatic write_modulus(input logic [W-1:0] value);
		modulus_valid <= 1'b1;
		modulus       <= value;
		do @(posedge clk); while (!modulus_ready);
		modulus_valid <= 1'b0;
		sb.modulus_now = value;
	endtask

	function automatic logic [W-1:0] pick_exponent();
		case ($urandom_range(0, 5))
			0:       return W'($urandom_range(0, 15));
			1:       return W'($urandom_range(0, 1023));
			2:       return ALL_ONES >> $urandom_range(0, W - 1);
			3:       return W'(1 << $urandom_range(0, W - 1));
			default: return W'($urandom);
		endcase
	endfunction

	// mix of small, near-modulus, above-modulus and full-width bases
	function automatic logic [W-1:0] pick_base(input logic [W-1:0] m);
		case ($urandom_range(0, 4))
			0:       return W'($urandom_range(0, 3));
			1:       return W'(m - $urandom_range(0, 2));
			2:       return W'(m + $urandom_range(0, 7));
			default: return W'($urandom);
		endcase
	endfunction

	initial begin
		logic [W-1:0] phase_modulus[PHASES];
		bit           gaps_on;

		// modulus settings: both extremes, tiny, even and the reset value again
		phase_modulus[0] = 1;
		phase_modulus[1] = ALL_ONES;
		phase_modulus[2] = 2;
		phase_modulus[3] = W'($urandom_range(3, 65535));
		phase_modulus[4] = {1'b1, (W-1)'($urandom)};
		phase_modulus[5] = 3;
		phase_modulus[6] = W'(1 << (W - 1));
		phase_modulus[7] = MODULUS_RESET[W-1:0];

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, under the reset modulus
		send_request(0, 0);
		send_request(ALL_ONES, 0);
		send_request(0, 1);
		send_request(0, ALL_ONES);
		send_request(ALL_ONES, 1);
		send_request(ALL_ONES, ALL_ONES);
		send_request(1, ALL_ONES);
		send_request(2, 30);
		// base equal to and above the modulus, then alternating bit patterns
		send_request(MODULUS_RESET[W-1:0], 5);
		send_request(W'(MODULUS_RESET[W-1:0] + 1), 7);
		send_request(W'(1 << (W - 1)), 2);
		send_request(W'({(W+1)/2{2'b01}}), W'({(W+1)/2{2'b10}}));
		send_request(W'({(W+1)/2{2'b10}}), W'({(W+1)/2{2'b01}}));
		// fermat: 3^(p-1) mod p is one
		send_request(3, W'(MODULUS_RESET[W-1:0] - 1));

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_modulus(phase_modulus[p]);
			// modulus of one: zero exponent still gives one, otherwise zero
			if (p == 0) begin
				send_request(7, 0);
				send_request(ALL_ONES, ALL_ONES);
			end
			// the last phases run with no sender idling
			gaps_on = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (gaps_on && $urandom_range(0, 2) == 0)
					request_gap();
				send_request(pick_base(phase_modulus[p]), pick_exponent());
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (sb.pending() != 0) begin
			$error("power_result: expected %0d, actual none", sb.expected_powers.pop_front());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/mexp_pkg.sv
rtl/mexp_mstep.sv
rtl/mexp_dp.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation_core.sv
rtl/mexp_chk.sv
dv/modular_exponentiation_core_tb.sv
